// ===== hw/rtl/chrl_pkg.sv =====
// Shared types, constants and helpers for the hash ring lookup block.
// No dependencies; every other file of the block but chrl_ram imports this package.
package chrl_pkg;

    localparam int RING_DEPTH = 1024;
    localparam int ADDR_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);
    localparam int POS_W      = 64;
    localparam int SRV_W      = 6;
    localparam int NSRV       = 64;
    localparam int N_W        = 7;
    localparam int ENTRY_W    = POS_W + SRV_W;

    localparam logic [63:0] FNV_BASIS   = 64'hCBF29CE484222325;
    localparam logic [63:0] FNV_PRIME_L = 64'h00000000000001B3;
    localparam int          FNV_SHIFT   = 40;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_BYTE   = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_FULL  = 2'd1;
    localparam logic [1:0] STS_EMPTY = 2'd2;

    localparam logic [1:0] CFG_SEED = 2'd0;
    localparam logic [1:0] CFG_REPL = 2'd1;
    localparam logic [1:0] CFG_SRVS = 2'd2;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    typedef struct packed {
        logic [1:0]       kind;
        logic [POS_W-1:0] ring_position;
        logic [SRV_W-1:0] ring_server;
        logic [7:0]       key_byte;
        logic             key_last;
    } t_in_word;

    typedef struct packed {
        logic [1:0]       status;
        logic [SRV_W-1:0] server;
        logic             last;
    } t_out_word;

    // command word passed from the front end to the ring engine
    typedef struct packed {
        t_op              op;
        logic [POS_W-1:0] key;
        logic [SRV_W-1:0] server;
    } t_cmd;

    typedef struct packed {
        logic [5:0] replicas;
        logic [6:0] servers;
    } t_ring_cfg;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    function automatic logic [63:0] start_value(input logic [31:0] seed);
        start_value = FNV_BASIS + {{32{seed[31]}}, seed};
    endfunction

endpackage

// ===== hw/rtl/consistent_hash_ring_lookup_top.sv =====
// Top level of the consistent hash ring lookup block.
// Uses chrl_pkg, chrl_front, chrl_queue and chrl_back.
//
// Words are taken at a clock edge with i_start high and o_busy low, unless a
// seed write comes in the same cycle. Key bytes are folded into the hash
// combinationally; inserts, clears and finished keys go through a two-entry
// queue to the ring engine, and o_busy is high while that queue is full.
// Results appear for one cycle each with o_valid and cannot be held off. An
// insert does a binary search, then shifts the tail up; a lookup does a binary
// search, then walks the points. The point memory needs no clearing after reset.
module consistent_hash_ring_lookup_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  chrl_pkg::t_in_word  i_in,
    output logic                o_valid,
    output chrl_pkg::t_out_word o_out,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_addr,
    input  logic [31:0]         i_cfg_data
);
    import chrl_pkg::*;

    logic [31:0] r_seed;
    t_ring_cfg   r_cfg;
    logic        w_push, w_pop, w_seed_wr;
    t_cmd        w_cmd, w_head;
    t_q_status   w_qstat;

    assign w_seed_wr = i_cfg_we && (i_cfg_addr == CFG_SEED);
    assign o_busy    = w_qstat.full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed        <= '0;
            r_cfg.replicas <= 6'd1;
            r_cfg.servers  <= 7'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_SEED: r_seed         <= i_cfg_data;
                CFG_REPL: r_cfg.replicas <= i_cfg_data[5:0];
                CFG_SRVS: r_cfg.servers  <= i_cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    chrl_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .i_full    (w_qstat.full),
        .i_in      (i_in),
        .i_seed_wr (w_seed_wr),
        .i_seed_new(i_cfg_data),
        .i_seed    (r_seed),
        .o_push    (w_push),
        .o_cmd     (w_cmd)
    );

    chrl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_status(w_qstat)
    );

    chrl_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (r_cfg),
        .i_head (w_head),
        .i_qstat(w_qstat),
        .o_pop  (w_pop),
        .o_valid(o_valid),
        .o_out  (o_out)
    );
endmodule

// ===== hw/rtl/chrl_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module chrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== hw/rtl/chrl_front.sv =====
// Front end: takes input words, folds sign-extended key bytes into an FNV-1a style hash and
// turns inserts, clears and finished keys into commands. Uses chrl_pkg.
module chrl_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_full,
    input  chrl_pkg::t_in_word i_in,
    input  logic               i_seed_wr,
    input  logic [31:0]        i_seed_new,
    input  logic [31:0]        i_seed,
    output logic               o_push,
    output chrl_pkg::t_cmd     o_cmd
);
    import chrl_pkg::*;

    logic [63:0] r_acc, n_acc;
    logic [63:0] w_x, w_hash;
    logic        w_take;

    assign w_take = i_start && !i_full;
    assign w_x    = r_acc ^ {{56{i_in.key_byte[7]}}, i_in.key_byte};
    // prime is 2^40 + 0x1B3, so the product is a shift plus a narrow multiply
    assign w_hash = (w_x << FNV_SHIFT) + (w_x * FNV_PRIME_L);

    always_comb begin
        n_acc  = r_acc;
        o_push = 1'b0;
        o_cmd  = '{op: OP_INSERT, key: i_in.ring_position, server: i_in.ring_server};
        if (i_seed_wr) begin
            n_acc = start_value(i_seed_new);
        end else if (w_take) begin
            case (i_in.kind)
                KIND_INSERT: begin
                    o_push = 1'b1;
                end
                KIND_BYTE: begin
                    o_cmd.op  = OP_LOOKUP;
                    o_cmd.key = w_hash;
                    if (i_in.key_last) begin
                        o_push = 1'b1;
                        n_acc  = start_value(i_seed);
                    end else begin
                        n_acc = w_hash;
                    end
                end
                KIND_CLEAR: begin
                    o_cmd.op = OP_CLEAR;
                    o_push   = 1'b1;
                    n_acc    = start_value(i_seed);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= FNV_BASIS;
        end else begin
            r_acc <= n_acc;
        end
    end
endmodule

// ===== hw/rtl/chrl_queue.sv =====
// Two-entry command queue between the front end and the ring engine.
// Uses chrl_pkg.
module chrl_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  chrl_pkg::t_cmd      i_cmd,
    input  logic                i_pop,
    output chrl_pkg::t_cmd      o_head,
    output chrl_pkg::t_q_status o_status
);
    import chrl_pkg::*;

    t_cmd       r_buf [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_head          = r_buf[r_rp];
    assign o_status.empty  = (r_cnt == 2'd0);
    assign o_status.full   = (r_cnt == 2'd2);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

// ===== hw/rtl/chrl_back.sv =====
// Ring engine: sorted insert with shifting, clear, and lookup with replica walk.
// Uses chrl_pkg and one chrl_ram for the ring points.
module chrl_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  chrl_pkg::t_ring_cfg i_cfg,
    input  chrl_pkg::t_cmd      i_head,
    input  chrl_pkg::t_q_status i_qstat,
    output logic                o_pop,
    output logic                o_valid,
    output chrl_pkg::t_out_word o_out
);
    import chrl_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SRCH  = 8'b0000_0010,
        S_CMP   = 8'b0000_0100,
        S_SHRD  = 8'b0000_1000,
        S_SHWR  = 8'b0001_0000,
        S_WRD   = 8'b0010_0000,
        S_WCMP  = 8'b0100_0000,
        S_FLUSH = 8'b1000_0000
    } t_state;

    t_state            r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_lo, n_lo, r_hi, n_hi, r_i, n_i, r_steps, n_steps;
    logic [ADDR_W-1:0] r_mid, n_mid, r_idx, n_idx;
    logic [N_W-1:0]    r_n, n_n;
    logic [NSRV-1:0]   r_seen, n_seen;
    logic [SRV_W-1:0]  r_pend, n_pend;
    logic              n_valid;
    t_out_word         n_out;

    logic              w_we;
    logic [ADDR_W-1:0] w_waddr, w_raddr;
    logic [ENTRY_W-1:0] w_wdata, w_rdata;
    logic [POS_W-1:0]  w_rpos;
    logic [SRV_W-1:0]  w_rsrv;
    logic [CNT_W:0]    w_sum;
    logic [N_W-1:0]    w_repl1, w_target;
    logic [CNT_W-1:0]  w_idx1, w_steps1;
    logic [N_W-1:0]    w_n1;

    chrl_ram #(.WIDTH(ENTRY_W), .DEPTH(RING_DEPTH)) u_ring (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_rpos   = w_rdata[ENTRY_W-1:SRV_W];
    assign w_rsrv   = w_rdata[SRV_W-1:0];
    assign w_sum    = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_repl1  = {1'b0, i_cfg.replicas} + 7'd1;
    assign w_target = (w_repl1 < i_cfg.servers) ? w_repl1 : i_cfg.servers;
    assign w_idx1   = {{(CNT_W-ADDR_W){1'b0}}, r_idx} + 1'b1;
    assign w_steps1 = r_steps + 1'b1;
    assign w_n1     = r_n + 1'b1;

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_count = r_count;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_i     = r_i;
        n_steps = r_steps;
        n_mid   = r_mid;
        n_idx   = r_idx;
        n_n     = r_n;
        n_seen  = r_seen;
        n_pend  = r_pend;
        n_valid = 1'b0;
        n_out   = '{status: STS_OK, server: '0, last: 1'b1};
        o_pop   = 1'b0;
        w_we    = 1'b0;
        w_waddr = r_i[ADDR_W-1:0];
        w_wdata = w_rdata;
        w_raddr = r_mid;
        case (r_state)
            S_IDLE: begin
                if (!i_qstat.empty) begin
                    o_pop = 1'b1;
                    n_cmd = i_head;
                    n_lo  = '0;
                    n_hi  = r_count;
                    case (i_head.op)
                        OP_CLEAR: begin
                            n_count = '0;
                            n_seen  = '0;
                            n_valid = 1'b1;
                        end
                        OP_INSERT: begin
                            if (r_count >= CNT_W'(RING_DEPTH)) begin
                                n_valid      = 1'b1;
                                n_out.status = STS_FULL;
                            end else begin
                                n_state = S_SRCH;
                            end
                        end
                        OP_LOOKUP: begin
                            n_seen = '0;
                            if (r_count == '0) begin
                                n_valid      = 1'b1;
                                n_out.status = STS_EMPTY;
                            end else begin
                                n_state = S_SRCH;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SRCH: begin
                if (r_lo < r_hi) begin
                    n_mid   = w_sum[ADDR_W:1];
                    w_raddr = w_sum[ADDR_W:1];
                    n_state = S_CMP;
                end else if (r_cmd.op == OP_INSERT) begin
                    n_i     = r_count;
                    n_state = S_SHRD;
                end else begin
                    n_idx   = (r_lo >= r_count) ? '0 : r_lo[ADDR_W-1:0];
                    w_raddr = n_idx;
                    n_n     = '0;
                    n_state = S_WCMP;
                end
            end
            S_CMP: begin
                // insert lands after equal positions, lookup on the first >= key
                if ((r_cmd.op == OP_INSERT) ? (w_rpos <= r_cmd.key) : (w_rpos < r_cmd.key)) begin
                    n_lo = {{(CNT_W-ADDR_W){1'b0}}, r_mid} + 1'b1;
                end else begin
                    n_hi = {{(CNT_W-ADDR_W){1'b0}}, r_mid};
                end
                n_state = S_SRCH;
            end
            S_SHRD: begin
                if (r_i > r_lo) begin
                    w_raddr = ADDR_W'(r_i - 1'b1);
                    n_state = S_SHWR;
                end else begin
                    w_we    = 1'b1;
                    w_waddr = r_lo[ADDR_W-1:0];
                    w_wdata = {r_cmd.key, r_cmd.server};
                    n_count = r_count + 1'b1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SHWR: begin
                w_we    = 1'b1;
                n_i     = r_i - 1'b1;
                n_state = S_SHRD;
            end
            S_WRD: begin
                n_idx   = (w_idx1 >= r_count) ? '0 : w_idx1[ADDR_W-1:0];
                w_raddr = n_idx;
                n_state = S_WCMP;
            end
            S_WCMP: begin
                if (r_n == '0) begin
                    n_pend  = w_rsrv;
                    n_seen  = NSRV'(1) << w_rsrv;
                    n_n     = 7'd1;
                    n_steps = CNT_W'(1);
                    n_state = ((i_cfg.replicas != '0) && (r_count > CNT_W'(1))
                               && (w_target > 7'd1)) ? S_WRD : S_FLUSH;
                end else begin
                    n_steps = w_steps1;
                    if (!r_seen[w_rsrv]) begin
                        n_seen[w_rsrv] = 1'b1;
                        n_valid        = 1'b1;
                        n_out.server   = r_pend;
                        n_out.last     = 1'b0;
                        n_pend         = w_rsrv;
                        n_n            = w_n1;
                    end
                    n_state = ((w_steps1 < r_count) && (n_n < w_target)) ? S_WRD : S_FLUSH;
                end
            end
            S_FLUSH: begin
                n_valid      = 1'b1;
                n_out.server = r_pend;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_i     <= n_i;
        r_steps <= n_steps;
        r_mid   <= n_mid;
        r_idx   <= n_idx;
        r_n     <= n_n;
        r_seen  <= n_seen;
        r_pend  <= n_pend;
        o_out   <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            o_valid <= n_valid;
        end
    end
endmodule
